// ===== sv/assert_macros.svh =====
// Assertion helper macros shared by the decoder RTL.
// Every macro samples on the rising edge of clock and is held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When ante holds, cons holds at the same edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When ante holds, cons holds at the following edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/x86d_pkg.sv =====
// Shared types and constants for the x86 subset instruction decoder.
// No dependencies; used by x86d_decode and x86_subset_instruction_decoder.
`default_nettype none

package x86d_pkg;

   localparam int unsigned MAX_LEN = 9;

   // opcode bytes
   localparam logic [7:0] OPC_SIZE_PREFIX = 8'h66;
   localparam logic [7:0] OPC_TWO_BYTE    = 8'h0F;
   localparam logic [7:0] OPC_GROUP_83    = 8'h83;
   localparam logic [7:0] OPC_NOP         = 8'h90;
   localparam logic [7:0] OPC_RET         = 8'hC3;
   localparam logic [7:0] OPC_LRET        = 8'hCB;
   localparam logic [7:0] OPC_INT3        = 8'hCC;
   localparam logic [7:0] OPC_INT         = 8'hCD;
   localparam logic [7:0] OPC_CLI         = 8'hFA;
   localparam logic [7:0] OPC_STI         = 8'hFB;
   localparam logic [7:0] OPC_HLT         = 8'hF4;
   localparam logic [7:0] OPC_PUSHF       = 8'h9C;
   localparam logic [7:0] OPC_POPF        = 8'h9D;
   localparam logic [7:0] OPC_PUSHA       = 8'h60;
   localparam logic [7:0] OPC_POPA        = 8'h61;
   localparam logic [7:0] OPC_LEAVE       = 8'hC9;
   localparam logic [7:0] OPC_PUSH_REG    = 8'b0101_0???;
   localparam logic [7:0] OPC_POP_REG     = 8'b0101_1???;
   localparam logic [7:0] OPC_PUSH_IMM32  = 8'h68;
   localparam logic [7:0] OPC_PUSH_IMM8   = 8'h6A;
   localparam logic [7:0] OPC_MOV_IMM32   = 8'b1011_1???;
   localparam logic [7:0] OPC_MOV_IMM8    = 8'b1011_0???;
   localparam logic [7:0] OPC_CALL        = 8'hE8;
   localparam logic [7:0] OPC_JMP32       = 8'hE9;
   localparam logic [7:0] OPC_JMP8        = 8'hEB;
   localparam logic [7:0] OPC_JCC8        = 8'b0111_????;
   localparam logic [7:0] OPC_JCC32       = 8'b1000_????;
   localparam logic [7:0] OPC_MOVZB       = 8'hB6;
   localparam logic [7:0] OPC_MOVZW       = 8'hB7;
   localparam logic [7:0] OPC_IMUL        = 8'hAF;
   localparam logic [7:0] OPC_MOV_ST      = 8'h89;
   localparam logic [7:0] OPC_MOV_LD      = 8'h8B;
   localparam logic [7:0] OPC_ADD_ST      = 8'h01;
   localparam logic [7:0] OPC_ADD_LD      = 8'h03;
   localparam logic [7:0] OPC_SUB_ST      = 8'h29;
   localparam logic [7:0] OPC_SUB_LD      = 8'h2B;
   localparam logic [7:0] OPC_XOR_ST      = 8'h31;
   localparam logic [7:0] OPC_XOR_LD      = 8'h33;
   localparam logic [7:0] OPC_CMP_ST      = 8'h39;
   localparam logic [7:0] OPC_CMP_LD      = 8'h3B;
   localparam logic [7:0] OPC_LEA         = 8'h8D;

   // operand layout codes
   localparam logic [1:0] LAYOUT_NONE  = 2'd0;
   localparam logic [1:0] LAYOUT_MODRM = 2'd1;
   localparam logic [1:0] LAYOUT_SIB   = 2'd2;

   typedef enum logic [5:0] {
      OP_NOP       = 6'd0,
      OP_RET       = 6'd1,
      OP_LRET      = 6'd2,
      OP_INT3      = 6'd3,
      OP_INT       = 6'd4,
      OP_CLI       = 6'd5,
      OP_STI       = 6'd6,
      OP_HLT       = 6'd7,
      OP_PUSHF     = 6'd8,
      OP_POPF      = 6'd9,
      OP_PUSHA     = 6'd10,
      OP_POPA      = 6'd11,
      OP_LEAVE     = 6'd12,
      OP_PUSH_REG  = 6'd13,
      OP_POP_REG   = 6'd14,
      OP_PUSH_I32  = 6'd15,
      OP_PUSH_I8   = 6'd16,
      OP_MOV_I32   = 6'd17,
      OP_MOV_I8    = 6'd18,
      OP_CALL      = 6'd19,
      OP_JMP32     = 6'd20,
      OP_JMP8      = 6'd21,
      OP_JCC8      = 6'd22,
      OP_JCC32     = 6'd23,
      OP_MOVZX     = 6'd24,
      OP_IMUL      = 6'd25,
      OP_MOV_ST    = 6'd26,
      OP_MOV_LD    = 6'd27,
      OP_ADD_ST    = 6'd28,
      OP_ADD_LD    = 6'd29,
      OP_SUB_ST    = 6'd30,
      OP_SUB_LD    = 6'd31,
      OP_XOR_ST    = 6'd32,
      OP_XOR_LD    = 6'd33,
      OP_CMP_ST    = 6'd34,
      OP_CMP_LD    = 6'd35,
      OP_LEA       = 6'd36,
      OP_GROUP_83  = 6'd37,
      OP_RAW       = 6'd38
   } operation_type;

   // bytes of the instruction under decode, index 0 first
   typedef logic [MAX_LEN-1:0][7:0] window_type;

   typedef struct packed {
      logic [31:0]        instr_address;
      logic [3:0]         instr_length;
      operation_type      operation;
      logic [3:0]         opcode_field;
      logic [7:0]         modrm_value;
      logic [7:0]         sib_value;
      logic [1:0]         operand_layout;
      logic signed [31:0] displacement;
      logic [31:0]        operand_value;
      logic               size_prefix_seen;
      logic               truncated;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/x86d_decode.sv =====
// Combinational length finder and field decoder for one buffered instruction.
// Depends on x86d_pkg (window, result and operation types, opcode constants).
`default_nettype none

module x86d_decode (
   input  x86d_pkg::window_type win,       // buffered bytes, new byte included
   input  logic [3:0]           num_bytes, // bytes present in win
   input  logic [31:0]          base_addr, // address of win[0]
   output logic                 complete,
   output x86d_pkg::result_type res
);

   function automatic logic [7:0] rd(input x86d_pkg::window_type w, input logic [3:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (idx < 4'(x86d_pkg::MAX_LEN)) begin
         b = w[idx];
      end
      return b;
   endfunction

   function automatic logic [31:0] rd_le4(input x86d_pkg::window_type w,
                                          input logic [3:0] idx);
      return {rd(w, idx + 4'd3), rd(w, idx + 4'd2), rd(w, idx + 4'd1), rd(w, idx)};
   endfunction

   logic                    pre;
   logic [7:0]              op;
   logic [7:0]              op2;
   x86d_pkg::operation_type opn;
   logic [3:0]              fld;
   logic [7:0]              modrm;
   logic [7:0]              sib;
   logic [1:0]              lay;
   logic                    has_m;
   logic                    isign;
   logic                    rel;
   logic                    known;
   logic [2:0]              dsz;
   logic [2:0]              isz;
   logic [3:0]              i0;
   logic [3:0]              i1;
   logic [3:0]              i2;
   logic [3:0]              i3;
   logic [3:0]              imm_idx;
   logic [3:0]              total;
   logic [7:0]              disp8;
   logic [31:0]             disp;
   logic [31:0]             imm_raw;
   logic [31:0]             val;

   always_comb begin
      pre   = (win[0] == x86d_pkg::OPC_SIZE_PREFIX);
      i0    = pre ? 4'd2 : 4'd1;
      op    = pre ? win[1] : win[0];
      op2   = 8'h00;
      opn   = x86d_pkg::OP_RAW;
      fld   = 4'd0;
      modrm = 8'h00;
      sib   = 8'h00;
      lay   = x86d_pkg::LAYOUT_NONE;
      has_m = 1'b0;
      isign = 1'b0;
      rel   = 1'b0;
      dsz   = 3'd0;
      isz   = 3'd0;
      known = (num_bytes >= i0);
      i1    = i0;

      case (op) inside
         x86d_pkg::OPC_NOP:   opn = x86d_pkg::OP_NOP;
         x86d_pkg::OPC_RET:   opn = x86d_pkg::OP_RET;
         x86d_pkg::OPC_LRET:  opn = x86d_pkg::OP_LRET;
         x86d_pkg::OPC_INT3:  opn = x86d_pkg::OP_INT3;
         x86d_pkg::OPC_INT: begin
            opn = x86d_pkg::OP_INT;
            isz = 3'd1;
         end
         x86d_pkg::OPC_CLI:   opn = x86d_pkg::OP_CLI;
         x86d_pkg::OPC_STI:   opn = x86d_pkg::OP_STI;
         x86d_pkg::OPC_HLT:   opn = x86d_pkg::OP_HLT;
         x86d_pkg::OPC_PUSHF: opn = x86d_pkg::OP_PUSHF;
         x86d_pkg::OPC_POPF:  opn = x86d_pkg::OP_POPF;
         x86d_pkg::OPC_PUSHA: opn = x86d_pkg::OP_PUSHA;
         x86d_pkg::OPC_POPA:  opn = x86d_pkg::OP_POPA;
         x86d_pkg::OPC_LEAVE: opn = x86d_pkg::OP_LEAVE;
         x86d_pkg::OPC_PUSH_REG: begin
            opn = x86d_pkg::OP_PUSH_REG;
            fld = {1'b0, op[2:0]};
         end
         x86d_pkg::OPC_POP_REG: begin
            opn = x86d_pkg::OP_POP_REG;
            fld = {1'b0, op[2:0]};
         end
         x86d_pkg::OPC_PUSH_IMM32: begin
            opn = x86d_pkg::OP_PUSH_I32;
            isz = 3'd4;
         end
         x86d_pkg::OPC_PUSH_IMM8: begin
            opn   = x86d_pkg::OP_PUSH_I8;
            isz   = 3'd1;
            isign = 1'b1;
         end
         x86d_pkg::OPC_MOV_IMM32: begin
            opn = x86d_pkg::OP_MOV_I32;
            fld = {1'b0, op[2:0]};
            isz = 3'd4;
         end
         x86d_pkg::OPC_MOV_IMM8: begin
            opn = x86d_pkg::OP_MOV_I8;
            fld = {1'b0, op[2:0]};
            isz = 3'd1;
         end
         x86d_pkg::OPC_CALL: begin
            opn = x86d_pkg::OP_CALL;
            isz = 3'd4;
            rel = 1'b1;
         end
         x86d_pkg::OPC_JMP32: begin
            opn = x86d_pkg::OP_JMP32;
            isz = 3'd4;
            rel = 1'b1;
         end
         x86d_pkg::OPC_JMP8: begin
            opn = x86d_pkg::OP_JMP8;
            isz = 3'd1;
            rel = 1'b1;
         end
         x86d_pkg::OPC_JCC8: begin
            opn = x86d_pkg::OP_JCC8;
            fld = op[3:0];
            isz = 3'd1;
            rel = 1'b1;
         end
         x86d_pkg::OPC_TWO_BYTE: begin
            op2   = rd(win, i0);
            i1    = i0 + 4'd1;
            known = known && (num_bytes > i0);
            case (op2) inside
               x86d_pkg::OPC_JCC32: begin
                  opn = x86d_pkg::OP_JCC32;
                  fld = op2[3:0];
                  isz = 3'd4;
                  rel = 1'b1;
               end
               x86d_pkg::OPC_MOVZB, x86d_pkg::OPC_MOVZW: begin
                  opn   = x86d_pkg::OP_MOVZX;
                  has_m = 1'b1;
               end
               x86d_pkg::OPC_IMUL: begin
                  opn   = x86d_pkg::OP_IMUL;
                  has_m = 1'b1;
               end
               default: opn = x86d_pkg::OP_RAW;
            endcase
         end
         x86d_pkg::OPC_GROUP_83: begin
            opn   = x86d_pkg::OP_GROUP_83;
            has_m = 1'b1;
            isz   = 3'd1;
            isign = 1'b1;
         end
         x86d_pkg::OPC_MOV_ST: begin opn = x86d_pkg::OP_MOV_ST; has_m = 1'b1; end
         x86d_pkg::OPC_MOV_LD: begin opn = x86d_pkg::OP_MOV_LD; has_m = 1'b1; end
         x86d_pkg::OPC_ADD_ST: begin opn = x86d_pkg::OP_ADD_ST; has_m = 1'b1; end
         x86d_pkg::OPC_ADD_LD: begin opn = x86d_pkg::OP_ADD_LD; has_m = 1'b1; end
         x86d_pkg::OPC_SUB_ST: begin opn = x86d_pkg::OP_SUB_ST; has_m = 1'b1; end
         x86d_pkg::OPC_SUB_LD: begin opn = x86d_pkg::OP_SUB_LD; has_m = 1'b1; end
         x86d_pkg::OPC_XOR_ST: begin opn = x86d_pkg::OP_XOR_ST; has_m = 1'b1; end
         x86d_pkg::OPC_XOR_LD: begin opn = x86d_pkg::OP_XOR_LD; has_m = 1'b1; end
         x86d_pkg::OPC_CMP_ST: begin opn = x86d_pkg::OP_CMP_ST; has_m = 1'b1; end
         x86d_pkg::OPC_CMP_LD: begin opn = x86d_pkg::OP_CMP_LD; has_m = 1'b1; end
         x86d_pkg::OPC_LEA:    begin opn = x86d_pkg::OP_LEA;    has_m = 1'b1; end
         default: opn = x86d_pkg::OP_RAW;
      endcase

      i2 = i1;
      i3 = i1;
      if (has_m) begin
         modrm = rd(win, i1);
         known = known && (num_bytes > i1);
         i2    = i1 + 4'd1;
         i3    = i2;
         lay   = x86d_pkg::LAYOUT_MODRM;
         if (opn == x86d_pkg::OP_GROUP_83) begin
            fld = {1'b0, modrm[5:3]};
         end
         if (modrm[7:6] != 2'd3) begin
            if (modrm[2:0] == 3'd4) begin
               // SIB follows; base 5 with mod 0 means a bare disp32
               sib   = rd(win, i2);
               known = known && (num_bytes > i2);
               i3    = i2 + 4'd1;
               lay   = x86d_pkg::LAYOUT_SIB;
               if ((modrm[7:6] == 2'd0) && (sib[2:0] == 3'd5)) begin
                  dsz = 3'd4;
               end
            end else if ((modrm[7:6] == 2'd0) && (modrm[2:0] == 3'd5)) begin
               dsz = 3'd4;
            end
            if (modrm[7:6] == 2'd1) begin
               dsz = 3'd1;
            end
            if (modrm[7:6] == 2'd2) begin
               dsz = 3'd4;
            end
         end
      end

      total   = i3 + {1'b0, dsz} + {1'b0, isz};
      imm_idx = i3 + {1'b0, dsz};

      disp8 = rd(win, i3);
      case (dsz)
         3'd1:    disp = {{24{disp8[7]}}, disp8};
         3'd4:    disp = rd_le4(win, i3);
         default: disp = 32'd0;
      endcase

      imm_raw = rd_le4(win, imm_idx);
      case (isz)
         3'd1: begin
            if (isign || rel) begin
               val = {{24{imm_raw[7]}}, imm_raw[7:0]};
            end else begin
               val = {24'd0, imm_raw[7:0]};
            end
         end
         3'd4:    val = imm_raw;
         default: val = 32'd0;
      endcase
      if (rel) begin
         val = base_addr + {28'd0, total} + val;
      end
      if (opn == x86d_pkg::OP_RAW) begin
         val = {24'd0, op};
      end

      complete = known && (num_bytes >= total);

      res.instr_address    = base_addr;
      res.instr_length     = total;
      res.operation        = opn;
      res.opcode_field     = fld;
      res.modrm_value      = modrm;
      res.sib_value        = sib;
      res.operand_layout   = lay;
      res.displacement     = $signed(disp);
      res.operand_value    = val;
      res.size_prefix_seen = pre;
      res.truncated        = 1'b0;
   end

endmodule

`default_nettype wire

// ===== sv/x86_subset_instruction_decoder.sv =====
// Streaming x86 subset decoder top level: byte buffer, address tracking, output skid.
// Depends on x86d_pkg, x86d_decode and assert_macros.svh.
// Results leave through the output register; one meeting a held output waits in the skid.
// Throughput: one code byte per cycle; the input stalls only when both the output
// register and the skid register hold words.
// Reset (synchronous, active high) empties the buffer and output, zeroes offset and base.
`default_nettype none
`include "assert_macros.svh"

module x86_subset_instruction_decoder (
   input  logic         clock,
   input  logic         reset,
   // configuration: section base address
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   // code bytes
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] code_byte
   input  logic         req_tlast,   // section_end
   // decoded instructions
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] instr_address, [35:32] instr_length, [41:36] operation,
   // [45:42] opcode_field, [53:46] modrm_value, [61:54] sib_value,
   // [63:62] operand_layout, [95:64] displacement, [127:96] operand_value
   output logic [127:0] rsp_tdata,
   output logic [1:0]   rsp_tuser    // [0] size_prefix_seen, [1] truncated
);

   logic [31:0]          base_ff;
   logic [31:0]          offset_ff;
   logic [31:0]          offset_in;
   logic [31:0]          addr_ff;     // base_ff + offset_ff
   logic [31:0]          addr_in;
   logic [3:0]           count_ff;
   logic [3:0]           count_in;
   logic [7:0]           pend_ff [0:7];

   x86d_pkg::window_type win;
   logic [3:0]           num_bytes;
   logic                 complete;
   x86d_pkg::result_type dec_res;
   x86d_pkg::result_type trunc_res;
   x86d_pkg::result_type res;
   logic                 accept;
   logic                 produce;
   logic                 trunc_pre;

   x86d_pkg::result_type out_ff;
   x86d_pkg::result_type out_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   x86d_pkg::result_type skid_ff;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic                 out_free;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign num_bytes  = count_ff + 4'd1;

   // new byte lands at the buffer position given by the fill count
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         win[k] = (count_ff == 4'(k)) ? req_tdata : pend_ff[k];
      end
      win[8] = req_tdata;
   end

   x86d_decode u_decode (
      .win       (win),
      .num_bytes (num_bytes),
      .base_addr (addr_ff),
      .complete  (complete),
      .res       (dec_res)
   );

   always_comb begin
      trunc_pre                  = (win[0] == x86d_pkg::OPC_SIZE_PREFIX);
      trunc_res                  = '0;
      trunc_res.instr_address    = addr_ff;
      trunc_res.instr_length     = num_bytes;
      trunc_res.operation        = x86d_pkg::OP_RAW;
      trunc_res.operand_value    = {24'd0, (trunc_pre && (count_ff != 4'd0)) ? win[1] : win[0]};
      trunc_res.size_prefix_seen = trunc_pre;
      trunc_res.truncated        = 1'b1;
   end

   assign res     = complete ? dec_res : trunc_res;
   assign produce = accept && (complete || req_tlast);

   // buffer and address bookkeeping
   always_comb begin
      count_in  = count_ff;
      offset_in = offset_ff;
      addr_in   = addr_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in  = 4'd0;
            offset_in = 32'd0;
            addr_in   = base_ff;
         end else if (complete) begin
            count_in  = 4'd0;
            offset_in = offset_ff + {28'd0, dec_res.instr_length};
            addr_in   = addr_ff + {28'd0, dec_res.instr_length};
         end else begin
            count_in  = num_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= 32'd0;
         offset_ff <= 32'd0;
         addr_ff   <= 32'd0;
         count_ff  <= 4'd0;
      end else begin
         offset_ff <= offset_in;
         count_ff  <= count_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
            addr_ff <= csr_wdata + offset_in;
         end else begin
            addr_ff <= addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !count_ff[3]) begin
         pend_ff[count_ff[2:0]] <= req_tdata;
      end
   end

   // output register with a skid word behind it
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = produce;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (!out_free && produce) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.operand_value, out_ff.displacement, out_ff.operand_layout,
                        out_ff.sib_value, out_ff.modrm_value, out_ff.opcode_field,
                        out_ff.operation, out_ff.instr_length, out_ff.instr_address};
   assign rsp_tuser  = {out_ff.truncated, out_ff.size_prefix_seen};

   `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || out_valid_ff, "skid word without output word")
   `ASSERT_ALWAYS(a_count_range, count_ff <= 4'd8, "buffer fill count beyond eight bytes")
   `ASSERT_NEXT(a_end_restarts, accept && req_tlast && !csr_we, (count_ff == 4'd0) && (offset_ff == 32'd0) && (addr_ff == base_ff), "section end did not restart offset")
   `ASSERT_IMPLY(a_len_nonzero, rsp_tvalid, (rsp_tdata[35:32] != 4'd0) && (rsp_tdata[35:32] <= 4'd9), "result length out of range")
   `ASSERT_ALWAYS(a_addr_track, addr_ff == base_ff + offset_ff, "address register lost track of base plus offset")

endmodule

`default_nettype wire
